// ===== hdl/msk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msk_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_RD,
        S_MIN_RD1,
        S_MIN_RD2,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic pop_commit;
        logic load_min_pos;
        logic load_min_val;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic op_pop;
        logic full;
        logic empty;
        logic drop_min;
        logic more_min;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/msk_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface stack_req_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [msk_pkg::VALUE_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface stack_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [msk_pkg::VALUE_W-1:0]  popped_value;
    logic signed [msk_pkg::VALUE_W-1:0]  min_value;
    logic                                 is_empty;
    logic [msk_pkg::COUNT_W-1:0]          count;
    logic [msk_pkg::STATUS_W-1:0]         status;

    modport source (output valid, output popped_value, output min_value, output is_empty,
                    output count, output status, input ready);
    modport sink   (input valid, input popped_value, input min_value, input is_empty,
                    input count, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/msk_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msk_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire msk_pkg::dp_status_t stat,
    output msk_pkg::dp_cmd_t         cmd,
    output msk_pkg::state_t          state
);

    msk_pkg::state_t state_reg;
    msk_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msk_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msk_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = msk_pkg::S_EXEC;
                end
            end
            msk_pkg::S_EXEC:
            begin
                if (stat.op_pop && !stat.empty)
                begin
                    state_next = msk_pkg::S_POP_RD;
                end
                else
                begin
                    state_next = msk_pkg::S_EMIT;
                end
            end
            msk_pkg::S_POP_RD:
            begin
                if (stat.drop_min && stat.more_min)
                begin
                    state_next = msk_pkg::S_MIN_RD1;
                end
                else
                begin
                    state_next = msk_pkg::S_EMIT;
                end
            end
            msk_pkg::S_MIN_RD1:
            begin
                state_next = msk_pkg::S_MIN_RD2;
            end
            msk_pkg::S_MIN_RD2:
            begin
                state_next = msk_pkg::S_EMIT;
            end
            msk_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = msk_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = msk_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            msk_pkg::S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            msk_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            msk_pkg::S_POP_RD:
            begin
                cmd.pop_commit = 1'b1;
            end
            msk_pkg::S_MIN_RD1:
            begin
                cmd.load_min_pos = 1'b1;
            end
            msk_pkg::S_MIN_RD2:
            begin
                cmd.load_min_val = 1'b1;
            end
            msk_pkg::S_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

`default_nettype wire

// ===== hdl/msk_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msk_datapath #(
    parameter int DEPTH = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_cmd,
    input  wire logic signed [msk_pkg::VALUE_W-1:0] req_push_value,
    input  wire msk_pkg::dp_cmd_t                   cmd,
    output msk_pkg::dp_status_t                     stat,
    stack_rsp_if.source                             rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [msk_pkg::VALUE_W-1:0] value_mem_reg [DEPTH];
    logic [AW-1:0]                      pos_mem_reg [DEPTH];

    logic                               op_cmd_reg;
    logic signed [msk_pkg::VALUE_W-1:0] op_value_reg;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [CW-1:0]                      min_count_reg;
    logic [CW-1:0]                      min_count_next;
    logic [AW-1:0]                      min_pos_reg;
    logic [AW-1:0]                      min_pos_next;
    logic signed [msk_pkg::VALUE_W-1:0] min_val_reg;
    logic signed [msk_pkg::VALUE_W-1:0] min_val_next;
    logic signed [msk_pkg::VALUE_W-1:0] popped_reg;
    logic signed [msk_pkg::VALUE_W-1:0] popped_next;
    logic [msk_pkg::STATUS_W-1:0]       status_reg;
    logic [msk_pkg::STATUS_W-1:0]       status_next;
    logic signed [msk_pkg::VALUE_W-1:0] value_rdata_reg;
    logic [AW-1:0]                      pos_rdata_reg;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [msk_pkg::VALUE_W-1:0] out_popped_reg;
    logic signed [msk_pkg::VALUE_W-1:0] out_min_reg;
    logic                               out_empty_reg;
    logic [msk_pkg::COUNT_W-1:0]        out_count_reg;
    logic [msk_pkg::STATUS_W-1:0]       out_status_reg;

    logic                               full;
    logic                               empty;
    logic                               is_pop;
    logic [AW-1:0]                      top_idx;
    logic                               record_min;
    logic                               push_ok;
    logic                               value_rd_en;
    logic [AW-1:0]                      value_rd_addr;
    logic                               pos_rd_en;
    logic [AW-1:0]                      pos_rd_addr;
    logic                               out_free;

    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign is_pop     = (op_cmd_reg == msk_pkg::CMD_POP);
    assign top_idx    = AW'(count_reg - CW'(1));
    assign record_min = (min_count_reg == '0) || (op_value_reg < min_val_reg);
    assign push_ok    = cmd.exec && !is_pop && !full;
    assign out_free   = !out_valid_reg || rsp.ready;

    assign value_rd_en   = (cmd.exec && is_pop && !empty) || cmd.load_min_pos;
    assign value_rd_addr = cmd.load_min_pos ? pos_rdata_reg : top_idx;
    assign pos_rd_en     = cmd.pop_commit && stat.drop_min && stat.more_min;
    assign pos_rd_addr   = AW'(min_count_reg - CW'(2));

    assign stat.op_pop   = is_pop;
    assign stat.full     = full;
    assign stat.empty    = empty;
    assign stat.drop_min = (min_count_reg != '0) && (min_pos_reg == top_idx);
    assign stat.more_min = (min_count_reg > CW'(1));
    assign stat.out_free = out_free;

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            value_mem_reg[AW'(count_reg)] <= op_value_reg;
        end
        if (value_rd_en)
        begin
            value_rdata_reg <= value_mem_reg[value_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok && record_min)
        begin
            pos_mem_reg[AW'(min_count_reg)] <= AW'(count_reg);
        end
        if (pos_rd_en)
        begin
            pos_rdata_reg <= pos_mem_reg[pos_rd_addr];
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        min_count_next = min_count_reg;
        min_pos_next   = min_pos_reg;
        min_val_next   = min_val_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        if (cmd.exec)
        begin
            popped_next = '0;
            if (is_pop)
            begin
                status_next = empty ? msk_pkg::ST_EMPTY : msk_pkg::ST_DONE;
            end
            else
            begin
                status_next = full ? msk_pkg::ST_FULL : msk_pkg::ST_DONE;
            end
            if (push_ok)
            begin
                count_next = count_reg + CW'(1);
                if (record_min)
                begin
                    min_count_next = min_count_reg + CW'(1);
                    min_pos_next   = AW'(count_reg);
                    min_val_next   = op_value_reg;
                end
            end
        end
        if (cmd.pop_commit)
        begin
            popped_next = value_rdata_reg;
            count_next  = count_reg - CW'(1);
            if (stat.drop_min)
            begin
                min_count_next = min_count_reg - CW'(1);
            end
        end
        if (cmd.load_min_pos)
        begin
            min_pos_next = pos_rdata_reg;
        end
        if (cmd.load_min_val)
        begin
            min_val_next = value_rdata_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            min_count_reg <= min_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_cmd_reg   <= req_cmd;
            op_value_reg <= req_push_value;
        end
        min_pos_reg <= min_pos_next;
        min_val_reg <= min_val_next;
        popped_reg  <= popped_next;
        status_reg  <= status_next;
        if (cmd.emit)
        begin
            out_popped_reg <= popped_reg;
            out_min_reg    <= empty ? '0 : min_val_reg;
            out_empty_reg  <= empty;
            out_count_reg  <= msk_pkg::COUNT_W'(count_reg);
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = out_popped_reg;
    assign rsp.min_value    = out_min_reg;
    assign rsp.is_empty     = out_empty_reg;
    assign rsp.count        = out_count_reg;
    assign rsp.status       = out_status_reg;

endmodule

`default_nettype wire

// ===== hdl/min_tracking_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded LIFO stack of signed 32-bit values that reports its minimum after every request.
// Each request yields one response with the popped value, the minimum, an empty flag, the
// count and a status; a push on a full stack or a pop on an empty one is refused and leaves
// the stack unchanged. The controller handles one request at a time: a push or a refused
// request runs through the execute and emit states, a pop adds a pop-commit state, and a
// pop that removes the minimum while an older one remains adds position and value reload
// states, as each of the position and value memories has a single registered read port.
// A new request is accepted once the previous response has moved into the output register.

module min_tracking_stack #(
    parameter int DEPTH = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    stack_req_if.sink   req,
    stack_rsp_if.source rsp
);

    msk_pkg::dp_cmd_t    cmd;
    msk_pkg::dp_status_t stat;
    msk_pkg::state_t     state;

    msk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd),
        .state     (state)
    );

    msk_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_cmd        (req.cmd),
        .req_push_value (req.push_value),
        .cmd            (cmd),
        .stat           (stat),
        .rsp            (rsp)
    );

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state == msk_pkg::S_EXEC))
        else $error("accepted request did not start execution");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.is_empty) |-> (rsp.count == '0 && rsp.min_value == '0))
        else $error("empty response carries a count or minimum");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != msk_pkg::ST_DONE) |-> (rsp.popped_value == '0))
        else $error("refused request returned a popped value");

    a_min_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (state == msk_pkg::S_MIN_RD2) |-> ($past(state) == msk_pkg::S_MIN_RD1))
        else $error("minimum reload out of sequence");

endmodule

`default_nettype wire

// ===== tb/sv/tb_min_tracking_stack.sv =====
`timescale 1ns / 1ps

module tb_min_tracking_stack;

    localparam int STACK_DEPTH    = 64;
    localparam int TOTAL_REQUESTS = 1900;
    localparam int PHASE_LEN      = 150;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic                               cmd;
        logic signed [msk_pkg::VALUE_W-1:0] value;
    } stack_req_t;

    typedef struct {
        logic signed [msk_pkg::VALUE_W-1:0] popped_value;
        logic signed [msk_pkg::VALUE_W-1:0] min_value;
        logic                               is_empty;
        logic [msk_pkg::COUNT_W-1:0]        count;
        logic [msk_pkg::STATUS_W-1:0]       status;
    } stack_rsp_t;

    logic clk;
    logic rst_n;

    stack_req_if req ();
    stack_rsp_if rsp ();

    min_tracking_stack #(
        .DEPTH(STACK_DEPTH)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    stack_req_t request_queue[$];
    stack_rsp_t expected_rsp_q[$];
    stack_req_t next_request;
    stack_rsp_t expected_rsp;
    int         issued_count;
    int         mismatch_count;
    int         drain_cycles;

    logic signed [msk_pkg::VALUE_W-1:0] held_values[STACK_DEPTH];
    int                                 min_positions[STACK_DEPTH];
    int                                 held_count;
    int                                 min_depth;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Idle percentage for the sender or the receiver in the current traffic phase.
    function automatic int idle_percent(input bit receiver);
        int phase;
        phase = (issued_count / PHASE_LEN) % 4;
        case (phase)
            1:       return receiver ? 0 : 66;
            2:       return receiver ? 66 : 0;
            3:       return 14;
            default: return 0;
        endcase
    endfunction

    function automatic stack_rsp_t apply_stack_request(
        input logic                               cmd,
        input logic signed [msk_pkg::VALUE_W-1:0] value);
        stack_rsp_t result;
        logic       record;
        int         top;
        result.popped_value = '0;
        result.status       = msk_pkg::ST_DONE;
        if (cmd == msk_pkg::CMD_PUSH)
        begin
            if (held_count >= STACK_DEPTH)
            begin
                result.status = msk_pkg::ST_FULL;
            end
            else
            begin
                record = (min_depth == 0);
                if (min_depth != 0)
                begin
                    record = value < held_values[min_positions[min_depth - 1]];
                end
                held_values[held_count] = value;
                if (record)
                begin
                    min_positions[min_depth] = held_count;
                    min_depth++;
                end
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                result.status = msk_pkg::ST_EMPTY;
            end
            else
            begin
                top = held_count - 1;
                result.popped_value = held_values[top];
                if (min_depth > 0 && min_positions[min_depth - 1] == top)
                begin
                    min_depth--;
                end
                held_count = top;
            end
        end
        result.min_value = '0;
        if (held_count != 0)
        begin
            result.min_value = held_values[min_positions[min_depth - 1]];
        end
        result.is_empty = (held_count == 0);
        result.count    = msk_pkg::COUNT_W'(held_count);
        return result;
    endfunction

    function automatic logic signed [msk_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $signed($urandom);
            5, 6, 7, 8:    return $signed($urandom_range(0, 8)) - 4;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic add_request(input logic cmd,
                               input logic signed [msk_pkg::VALUE_W-1:0] value);
        stack_req_t item;
        item.cmd   = cmd;
        item.value = value;
        request_queue.push_back(item);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid      <= 1'b0;
            req.cmd        <= msk_pkg::CMD_PUSH;
            req.push_value <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= idle_percent(1'b0))
            begin
                next_request = request_queue.pop_front();
                req.valid      <= 1'b1;
                req.cmd        <= next_request.cmd;
                req.push_value <= next_request.value;
                issued_count++;
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= ($urandom_range(0, 99) >= idle_percent(1'b1));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                expected_rsp_q.push_back(apply_stack_request(req.cmd, req.push_value));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%t: response with no request pending: popped %0d min %0d",
                                 $realtime, rsp.popped_value, rsp.min_value);
                    end
                end
                else
                begin
                    expected_rsp = expected_rsp_q.pop_front();
                    if (rsp.popped_value !== expected_rsp.popped_value ||
                        rsp.min_value !== expected_rsp.min_value ||
                        rsp.is_empty !== expected_rsp.is_empty ||
                        rsp.count !== expected_rsp.count ||
                        rsp.status !== expected_rsp.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("%t: expected popped %0d min %0d empty %0b count %0d status %0d",
                                     $realtime, expected_rsp.popped_value,
                                     expected_rsp.min_value, expected_rsp.is_empty,
                                     expected_rsp.count, expected_rsp.status);
                            $display("%t: actual   popped %0d min %0d empty %0b count %0d status %0d",
                                     $realtime, rsp.popped_value, rsp.min_value,
                                     rsp.is_empty, rsp.count, rsp.status);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("min_tracking_stack regression: fail");
        $finish;
    end

    initial
    begin
        int burst_len;
        int push_pct;
        req.valid      = 1'b0;
        req.cmd        = msk_pkg::CMD_PUSH;
        req.push_value = '0;
        rsp.ready      = 1'b0;
        rst_n          = 1'b0;
        issued_count   = 0;
        mismatch_count = 0;
        held_count     = 0;
        min_depth      = 0;

        // The equal-minimum pushes check that only a strictly smaller value is recorded.
        add_request(msk_pkg::CMD_POP, 32'sh0);
        add_request(msk_pkg::CMD_PUSH, 32'sh7FFF_FFFF);
        add_request(msk_pkg::CMD_PUSH, 32'sh0);
        add_request(msk_pkg::CMD_PUSH, 32'sh0);
        add_request(msk_pkg::CMD_PUSH, -32'sd1);
        add_request(msk_pkg::CMD_PUSH, 32'sh8000_0000);
        add_request(msk_pkg::CMD_PUSH, 32'sh8000_0000);
        add_request(msk_pkg::CMD_POP, -32'sd1);
        add_request(msk_pkg::CMD_POP, 32'sh7FFF_FFFF);
        add_request(msk_pkg::CMD_PUSH, 32'sh5555_5555);
        add_request(msk_pkg::CMD_PUSH, 32'shAAAA_AAAA);
        add_request(msk_pkg::CMD_POP, 32'sh5555_5555);
        add_request(msk_pkg::CMD_POP, 32'sh0);
        add_request(msk_pkg::CMD_POP, 32'sh0);
        add_request(msk_pkg::CMD_POP, 32'sh0);
        add_request(msk_pkg::CMD_POP, 32'sh0);
        add_request(msk_pkg::CMD_POP, 32'sh0);
        add_request(msk_pkg::CMD_POP, 32'shAAAA_AAAA);
        add_request(msk_pkg::CMD_PUSH, 32'sd5);
        add_request(msk_pkg::CMD_POP, 32'sh0);

        // Bursts that lean toward filling or draining reach both the full and the empty stack.
        while (request_queue.size() < TOTAL_REQUESTS)
        begin
            burst_len = $urandom_range(20, 160);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            repeat (burst_len)
            begin
                add_request(($urandom_range(0, 99) < push_pct) ? msk_pkg::CMD_PUSH
                                                               : msk_pkg::CMD_POP,
                            random_value());
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (request_queue.size() != 0 || req.valid)
        begin
            @(posedge clk);
        end
        drain_cycles = 0;
        while (expected_rsp_q.size() != 0 && drain_cycles < 20000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (20) @(posedge clk);
        mismatch_count += expected_rsp_q.size();

        if (mismatch_count == 0)
        begin
            $display("min_tracking_stack regression: pass");
        end
        else
        begin
            $display("min_tracking_stack regression: fail");
        end
        $finish;
    end

endmodule
